[rtl/energy_meter_accumulator_assert.svh]
// Assertion macros for the energy meter accumulator.
// Used inside modules that have aclk and aresetn in scope.
`ifndef ENERGY_METER_ACCUMULATOR_ASSERT_SVH
`define ENERGY_METER_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define EMACC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define EMACC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/emacc_pkg.sv]
// Shared types and constants of the energy meter accumulator.
// No dependencies; used by emacc_div and energy_meter_accumulator.
package emacc_pkg;

    localparam int APB_ADDR_W = 3;
    localparam logic REG_LINE_VOLTAGE = 1'b0;
    localparam logic [8:0] LINE_VOLTAGE_RESET = 9'd230;

    // milliamp-milliseconds per watt-hour at one volt
    localparam logic [31:0] WH_DIVISOR = 32'd3600000000;

    localparam logic [6:0] DIV_STEPS_AVG = 7'd16;
    localparam logic [6:0] DIV_STEPS_WH  = 7'd64;
    localparam logic [4:0] MUL_STEPS_AVG  = 5'd16;
    localparam logic [4:0] MUL_STEPS_VOLT = 5'd9;
    localparam logic [4:0] MUL_STEPS_SPAN = 5'd25;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_REMOTE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SMUL,
        ST_SCHK,
        ST_SDIV,
        ST_EPREP,
        ST_EMUL1,
        ST_EMUL2,
        ST_EADD,
        ST_EDIV,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic       start;
        logic [6:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

endpackage

[rtl/emacc_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on emacc_pkg for the request and response structs.
module emacc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  emacc_pkg::div_req_t req,
    input  logic [63:0]         dividend,
    input  logic [31:0]         rem_init,
    input  logic [31:0]         divisor,
    output emacc_pkg::div_rsp_t rsp,
    output logic [31:0]         quotient,
    output logic [31:0]         remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [63:0] dvd_reg;
    logic [31:0] quo_reg;
    logic [31:0] dsr_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    // remainder stays below the divisor, so the shifted trial fits 33 bits
    always_comb begin
        trial = {rem_reg, dvd_reg[63]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= rem_init;
            dvd_reg <= dividend;
            quo_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[31:0] : trial[31:0];
            dvd_reg <= {dvd_reg[62:0], 1'b0};
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/energy_meter_accumulator.sv]
// Energy meter accumulator: time-weighted average current and watt-hour counter.
// Depends on emacc_pkg, emacc_div and energy_meter_accumulator_assert.svh.
//
// Usage:
//   Input channel s_*: one transaction carries command, timestamp_ms,
//   current_ma and remote_value. Output channel m_*: one result per input
//   transaction with energy_count, present_ma, average_ma and ready_res.
//   APB port: register 0 (line_voltage, 9 bits) at byte address 0; write it
//   only while the block is idle. pready is tied high.
// Operation:
//   One item is worked at a time. Remote-add and clear pass through the
//   push state to the output register. A sample whose window is open runs
//   a shift-add multiply, a range check and, unless the average saturates,
//   a serial divide. An energy update adds two serial multiplies and a
//   serial divide by 3600000000. The bit-serial multiplier and the shared
//   one-bit-per-cycle divider do this work.
// Reset clears all accumulator state and sets line_voltage to 230. While
// the receiver stalls, the result waits in the output register; the next
// item is still taken and held at its last step until the register frees.
`include "energy_meter_accumulator_assert.svh"

module energy_meter_accumulator (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_command,
    input  logic [31:0]                      s_timestamp_ms,
    input  logic [15:0]                      s_current_ma,
    input  logic [31:0]                      s_remote_value,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [31:0]                      m_energy_count,
    output logic [15:0]                      m_present_ma,
    output logic [15:0]                      m_average_ma,
    output logic                             m_ready_res,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [emacc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    emacc_pkg::state_t state_reg;
    emacc_pkg::state_t state_next;
    emacc_pkg::cmd_t   cmd_reg;
    emacc_pkg::cmd_t   s_cmd;

    logic [8:0]  line_voltage_reg;

    logic        started_reg;
    logic [31:0] window_start_reg;
    logic [31:0] last_sample_reg;
    logic [15:0] present_reg;
    logic [15:0] average_reg;
    logic [31:0] remainder_reg;
    logic [31:0] counter_reg;
    logic        loaded_reg;

    logic [57:0] acc_reg;
    logic [24:0] mul_sh_reg;
    logic [15:0] pc_sh_reg;
    logic [31:0] span_a_reg;
    logic [31:0] span_b_reg;
    logic [31:0] total_reg;
    logic [4:0]  cnt_reg;

    logic        m_valid_reg;
    logic [31:0] m_energy_count_reg;
    logic [15:0] m_present_ma_reg;
    logic [15:0] m_average_ma_reg;
    logic        m_ready_res_reg;

    logic        accept;
    logic        is_upd;
    logic        window_hit;
    logic        open_window;
    logic [15:0] smp_cur;
    logic [57:0] acc_next;
    logic        mul_last;
    logic        avg_sat;
    logic        out_free;
    logic [57:0] energy_sum;
    logic        cfg_write;
    logic        div_phase;

    emacc_pkg::div_req_t div_req;
    emacc_pkg::div_rsp_t div_rsp;
    logic [63:0] div_dividend;
    logic [31:0] div_rem_init;
    logic [31:0] div_divisor;
    logic [31:0] div_quotient;
    logic [31:0] div_remainder;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[emacc_pkg::APB_ADDR_W-1] == emacc_pkg::REG_LINE_VOLTAGE);

    always_comb begin
        if (paddr[emacc_pkg::APB_ADDR_W-1] == emacc_pkg::REG_LINE_VOLTAGE) begin
            prdata = {23'd0, line_voltage_reg};
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_voltage_reg <= emacc_pkg::LINE_VOLTAGE_RESET;
        end else if (cfg_write) begin
            line_voltage_reg <= pwdata[8:0];
        end
    end

    // ---------------------------------------------------------------- decode
    assign s_ready     = (state_reg == emacc_pkg::ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign s_cmd       = emacc_pkg::cmd_t'(s_command);
    assign is_upd      = (s_cmd == emacc_pkg::CMD_UPDATE);
    assign smp_cur     = is_upd ? present_reg : s_current_ma;
    assign window_hit  = (s_timestamp_ms == window_start_reg);
    assign open_window = started_reg && !window_hit;
    assign out_free    = !m_valid_reg || m_ready;

    // one shift-add step: msb of each multiplier shift register gates its addend
    always_comb begin
        acc_next = {acc_reg[56:0], 1'b0}
                   + (mul_sh_reg[24] ? {26'd0, span_a_reg} : 58'd0)
                   + (pc_sh_reg[15]  ? {26'd0, span_b_reg} : 58'd0);
    end

    assign mul_last   = (cnt_reg == 5'd1);
    // quotient overflows 16 bits when the top of the numerator reaches the divisor
    assign avg_sat    = (acc_reg[48:16] >= {1'b0, total_reg});
    assign energy_sum = acc_reg + {26'd0, remainder_reg};

    // ---------------------------------------------------------------- divider
    always_comb begin
        div_req.start = 1'b0;
        div_req.steps = emacc_pkg::DIV_STEPS_AVG;
        div_dividend  = {acc_reg[15:0], 48'd0};
        div_rem_init  = acc_reg[47:16];
        div_divisor   = total_reg;
        if (state_reg == emacc_pkg::ST_SCHK) begin
            div_req.start = !avg_sat;
        end else if (state_reg == emacc_pkg::ST_EADD) begin
            div_req.start = 1'b1;
            div_req.steps = emacc_pkg::DIV_STEPS_WH;
            div_dividend  = {6'd0, energy_sum};
            div_rem_init  = '0;
            div_divisor   = emacc_pkg::WH_DIVISOR;
        end
    end

    emacc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req),
        .dividend  (div_dividend),
        .rem_init  (div_rem_init),
        .divisor   (div_divisor),
        .rsp       (div_rsp),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // ---------------------------------------------------------------- FSM
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= emacc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            emacc_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (s_cmd)
                        emacc_pkg::CMD_SAMPLE,
                        emacc_pkg::CMD_UPDATE: begin
                            if (open_window) begin
                                state_next = emacc_pkg::ST_SMUL;
                            end else if (is_upd) begin
                                state_next = emacc_pkg::ST_EPREP;
                            end else begin
                                state_next = emacc_pkg::ST_PUSH;
                            end
                        end
                        emacc_pkg::CMD_REMOTE,
                        emacc_pkg::CMD_CLEAR: begin
                            state_next = emacc_pkg::ST_PUSH;
                        end
                        default: state_next = emacc_pkg::ST_PUSH;
                    endcase
                end
            end
            emacc_pkg::ST_SMUL: begin
                if (mul_last) begin
                    state_next = emacc_pkg::ST_SCHK;
                end
            end
            emacc_pkg::ST_SCHK: begin
                if (!avg_sat) begin
                    state_next = emacc_pkg::ST_SDIV;
                end else if (cmd_reg == emacc_pkg::CMD_UPDATE) begin
                    state_next = emacc_pkg::ST_EPREP;
                end else begin
                    state_next = emacc_pkg::ST_PUSH;
                end
            end
            emacc_pkg::ST_SDIV: begin
                if (div_rsp.done) begin
                    state_next = (cmd_reg == emacc_pkg::CMD_UPDATE) ? emacc_pkg::ST_EPREP
                                                                    : emacc_pkg::ST_PUSH;
                end
            end
            emacc_pkg::ST_EPREP: state_next = emacc_pkg::ST_EMUL1;
            emacc_pkg::ST_EMUL1: begin
                if (mul_last) begin
                    state_next = emacc_pkg::ST_EMUL2;
                end
            end
            emacc_pkg::ST_EMUL2: begin
                if (mul_last) begin
                    state_next = emacc_pkg::ST_EADD;
                end
            end
            emacc_pkg::ST_EADD: state_next = emacc_pkg::ST_EDIV;
            emacc_pkg::ST_EDIV: begin
                if (div_rsp.done) begin
                    state_next = emacc_pkg::ST_PUSH;
                end
            end
            emacc_pkg::ST_PUSH: begin
                if (out_free) begin
                    state_next = emacc_pkg::ST_IDLE;
                end
            end
            default: state_next = emacc_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg      <= 1'b0;
            window_start_reg <= '0;
            last_sample_reg  <= '0;
            present_reg      <= '0;
            average_reg      <= '0;
            remainder_reg    <= '0;
            counter_reg      <= '0;
            loaded_reg       <= 1'b0;
        end else begin
            unique case (state_reg)
                emacc_pkg::ST_IDLE: begin
                    if (accept) begin
                        unique case (s_cmd)
                            emacc_pkg::CMD_SAMPLE,
                            emacc_pkg::CMD_UPDATE: begin
                                if (!started_reg) begin
                                    window_start_reg <= s_timestamp_ms;
                                    started_reg      <= 1'b1;
                                end else if (window_hit) begin
                                    average_reg <= '0;
                                end
                                present_reg     <= smp_cur;
                                last_sample_reg <= s_timestamp_ms;
                            end
                            emacc_pkg::CMD_REMOTE: begin
                                counter_reg <= counter_reg + s_remote_value;
                                loaded_reg  <= 1'b1;
                            end
                            emacc_pkg::CMD_CLEAR: begin
                                started_reg      <= 1'b0;
                                window_start_reg <= '0;
                                last_sample_reg  <= '0;
                                present_reg      <= '0;
                                average_reg      <= '0;
                                remainder_reg    <= '0;
                                counter_reg      <= '0;
                                loaded_reg       <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                emacc_pkg::ST_SCHK: begin
                    if (avg_sat) begin
                        average_reg <= 16'hFFFF;
                    end
                end
                emacc_pkg::ST_SDIV: begin
                    if (div_rsp.done) begin
                        average_reg <= div_quotient[15:0];
                    end
                end
                emacc_pkg::ST_EDIV: begin
                    if (div_rsp.done) begin
                        counter_reg      <= counter_reg + div_quotient;
                        remainder_reg    <= div_remainder;
                        window_start_reg <= last_sample_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- serial multiplier
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            emacc_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd_reg <= s_cmd;
                    // spans from the window as it stood before this sample
                    span_a_reg <= last_sample_reg - window_start_reg;
                    span_b_reg <= s_timestamp_ms - last_sample_reg;
                    total_reg  <= s_timestamp_ms - window_start_reg;
                    mul_sh_reg <= {average_reg, 9'd0};
                    pc_sh_reg  <= present_reg;
                    acc_reg    <= '0;
                    cnt_reg    <= emacc_pkg::MUL_STEPS_AVG;
                end
            end
            emacc_pkg::ST_SMUL,
            emacc_pkg::ST_EMUL2: begin
                acc_reg    <= acc_next;
                mul_sh_reg <= {mul_sh_reg[23:0], 1'b0};
                pc_sh_reg  <= {pc_sh_reg[14:0], 1'b0};
                cnt_reg    <= cnt_reg - 5'd1;
            end
            emacc_pkg::ST_EPREP: begin
                span_a_reg <= {16'd0, average_reg};
                span_b_reg <= last_sample_reg - window_start_reg;
                mul_sh_reg <= {line_voltage_reg, 16'd0};
                pc_sh_reg  <= '0;
                acc_reg    <= '0;
                cnt_reg    <= emacc_pkg::MUL_STEPS_VOLT;
            end
            emacc_pkg::ST_EMUL1: begin
                cnt_reg <= cnt_reg - 5'd1;
                if (mul_last) begin
                    // reload: average times voltage becomes the next multiplier
                    mul_sh_reg <= acc_next[24:0];
                    span_a_reg <= span_b_reg;
                    acc_reg    <= '0;
                    cnt_reg    <= emacc_pkg::MUL_STEPS_SPAN;
                end else begin
                    acc_reg    <= acc_next;
                    mul_sh_reg <= {mul_sh_reg[23:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == emacc_pkg::ST_PUSH && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == emacc_pkg::ST_PUSH && out_free) begin
            m_energy_count_reg <= counter_reg;
            m_present_ma_reg   <= present_reg;
            m_average_ma_reg   <= average_reg;
            m_ready_res_reg    <= loaded_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_energy_count = m_energy_count_reg;
    assign m_present_ma   = m_present_ma_reg;
    assign m_average_ma   = m_average_ma_reg;
    assign m_ready_res    = m_ready_res_reg;

    // ---------------------------------------------------------------- assertions
    assign div_phase = (state_reg == emacc_pkg::ST_SDIV) || (state_reg == emacc_pkg::ST_EDIV);

    `EMACC_ASSERT_SAME(a_rem_below_wh, 1'b1, remainder_reg < emacc_pkg::WH_DIVISOR, "remainder big")
    `EMACC_ASSERT_SAME(a_idle_avg_zero, !started_reg, average_reg == 16'd0, "average before start")
    `EMACC_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "input taken while busy")
    `EMACC_ASSERT_SAME(a_div_in_div_state, div_rsp.busy, div_phase, "divider runs outside divide")

endmodule

[verif/meter_tracker.sv]
`timescale 1ns / 100ps
// Result checker for energy_meter_accumulator: tracks line voltage from APB writes,
// predicts each result from the input transactions and compares the result channel.
// Depends on emacc_pkg.
module meter_tracker
    import emacc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic [31:0]           s_timestamp_ms,
    input  logic [15:0]           s_current_ma,
    input  logic [31:0]           s_remote_value,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [31:0]           m_energy_count,
    input  logic [15:0]           m_present_ma,
    input  logic [15:0]           m_average_ma,
    input  logic                  m_ready_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output int                    fail_count,
    output int                    readings_pending
);

    localparam logic [APB_ADDR_W-1:0] VOLT_ADDR = {REG_LINE_VOLTAGE, 2'b00};
    localparam logic [63:0] MA_MS_PER_WH = 64'd3600000000;

    typedef struct packed {
        logic [31:0] energy_count;
        logic [15:0] present_ma;
        logic [15:0] average_ma;
        logic        ready_res;
    } meter_reading_t;

    meter_reading_t readings_due[$];
    int             mismatches = 0;

    logic [8:0]  volts;
    logic        window_open;
    logic [31:0] win_start;
    logic [31:0] last_ts;
    logic [15:0] cur_now;
    logic [15:0] avg_now;
    logic [31:0] wh_rem;
    logic [31:0] wh_count;
    logic        remote_seen;

    initial begin
        fail_count = 0;
        readings_pending = 0;
    end

    function automatic void clear_meter();
        window_open = 1'b0;
        win_start   = '0;
        last_ts     = '0;
        cur_now     = '0;
        avg_now     = '0;
        wh_rem      = '0;
        wh_count    = '0;
        remote_seen = 1'b0;
    endfunction

    // Weight the running average by time spent at the previous current.
    function automatic void fold_sample(logic [31:0] ts, logic [15:0] cur);
        logic [31:0] span_old;
        logic [31:0] span_new;
        logic [31:0] span_all;
        logic [63:0] weighted;
        logic [63:0] avg_full;
        if (!window_open) begin
            win_start   = ts;
            window_open = 1'b1;
        end else if (ts == win_start) begin
            avg_now = '0;
        end else begin
            span_old = last_ts - win_start;
            span_new = ts - last_ts;
            span_all = ts - win_start;
            weighted = 64'(avg_now) * 64'(span_old) + 64'(cur_now) * 64'(span_new);
            avg_full = weighted / 64'(span_all);
            avg_now  = (avg_full > 64'hFFFF) ? 16'hFFFF : avg_full[15:0];
        end
        cur_now = cur;
        last_ts = ts;
    endfunction

    // Close the window at ts and move whole watt-hours into the counter.
    function automatic void close_window(logic [31:0] ts);
        logic [31:0] span;
        logic [63:0] charge;
        logic [63:0] whole;
        logic [63:0] left;
        fold_sample(ts, cur_now);
        span     = last_ts - win_start;
        charge   = 64'(avg_now) * 64'(volts) * 64'(span) + 64'(wh_rem);
        whole    = charge / MA_MS_PER_WH;
        left     = charge % MA_MS_PER_WH;
        wh_count = wh_count + whole[31:0];
        wh_rem   = left[31:0];
        win_start = last_ts;
    endfunction

    function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        mismatches++;
    endfunction

    always @(posedge aclk) begin
        meter_reading_t want;
        if (!aresetn) begin
            volts = LINE_VOLTAGE_RESET;
            clear_meter();
            readings_due.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == VOLT_ADDR)
                volts = pwdata[8:0];

            // Retire first: a result can never belong to an item taken at the same edge.
            if (m_valid && m_ready) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: result expected none got %0d %0d %0d %0d", $time,
                             m_energy_count, m_present_ma, m_average_ma, m_ready_res);
                    mismatches++;
                end else begin
                    want = readings_due.pop_front();
                    if (m_energy_count !== want.energy_count)
                        note_mismatch("energy_count", want.energy_count, m_energy_count);
                    if (m_present_ma !== want.present_ma)
                        note_mismatch("present_ma", 32'(want.present_ma), 32'(m_present_ma));
                    if (m_average_ma !== want.average_ma)
                        note_mismatch("average_ma", 32'(want.average_ma), 32'(m_average_ma));
                    if (m_ready_res !== want.ready_res)
                        note_mismatch("ready_res", 32'(want.ready_res), 32'(m_ready_res));
                end
            end

            if (s_valid && s_ready) begin
                case (cmd_t'(s_command))
                    CMD_SAMPLE: fold_sample(s_timestamp_ms, s_current_ma);
                    CMD_UPDATE: close_window(s_timestamp_ms);
                    CMD_REMOTE: begin
                        wh_count    = wh_count + s_remote_value;
                        remote_seen = 1'b1;
                    end
                    default: clear_meter();
                endcase
                want.energy_count = wh_count;
                want.present_ma   = cur_now;
                want.average_ma   = avg_now;
                want.ready_res    = remote_seen;
                readings_due.push_back(want);
            end
        end
        fail_count       <= mismatches;
        readings_pending <= readings_due.size();
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Top of the energy_meter_accumulator test: clock, reset, APB writes, input
// stimulus and result back-pressure. Depends on emacc_pkg and meter_tracker.
module testbench;
    import emacc_pkg::*;

    localparam logic [APB_ADDR_W-1:0] VOLT_ADDR = {REG_LINE_VOLTAGE, 2'b00};
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 200;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_SAMPLE;
    logic [31:0] s_timestamp_ms = '0;
    logic [15:0] s_current_ma = '0;
    logic [31:0] s_remote_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_energy_count;
    logic [15:0] m_present_ma;
    logic [15:0] m_average_ma;
    logic        m_ready_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          readings_pending;
    int          quiet_cycles = 0;
    int          burst_left = 0;
    rx_mode_t    rx_mode = RX_OPEN;
    int          rx_left = 0;
    logic [2:0]  rx_tick = '0;
    logic [31:0] clock_ms;

    always #6 aclk = ~aclk;

    energy_meter_accumulator uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_timestamp_ms (s_timestamp_ms),
        .s_current_ma   (s_current_ma),
        .s_remote_value (s_remote_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_energy_count (m_energy_count),
        .m_present_ma   (m_present_ma),
        .m_average_ma   (m_average_ma),
        .m_ready_res    (m_ready_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    meter_tracker tracker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_timestamp_ms   (s_timestamp_ms),
        .s_current_ma     (s_current_ma),
        .s_remote_value   (s_remote_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_energy_count   (m_energy_count),
        .m_present_ma     (m_present_ma),
        .m_average_ma     (m_average_ma),
        .m_ready_res      (m_ready_res),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .fail_count       (fail_count),
        .readings_pending (readings_pending)
    );

    // Receiver back-pressure: hold a randomly chosen stall pattern, then pick another.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 3'd1;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
            default:   m_ready <= rx_tick[2];
        endcase
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("energy_meter_accumulator: mismatch");
                $finish;
            end
        end
    end

    // Present one input transaction and hold it until accepted.
    task automatic send_item(cmd_t op, logic [31:0] ts, logic [15:0] ma, logic [31:0] wh);
        logic took;
        s_valid        <= 1'b1;
        s_command      <= op;
        s_timestamp_ms <= ts;
        s_current_ma   <= ma;
        s_remote_value <= wh;
        took = 1'b0;
        while (!took) begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end
    endtask

    // Bursts of back-to-back transactions separated by random gaps.
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (readings_pending != 0);
    endtask

    task automatic write_voltage(logic [8:0] volts);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VOLT_ADDR;
        pwdata  <= {23'd0, volts};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_directed();
        // update before any sample opens the window without adding energy
        send_item(CMD_UPDATE, 32'd100, 16'h0000, 32'h0000_0000);
        // zero-length window drops the average to zero
        send_item(CMD_SAMPLE, 32'd100, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_SAMPLE, 32'd1100, 16'h0000, 32'h0000_0000);
        send_item(CMD_UPDATE, 32'd3601100, 16'hFFFF, 32'h0000_0000);
        // timestamps running backwards wrap the unsigned spans
        send_item(CMD_SAMPLE, 32'h0001_0000, 16'h5A5A, 32'h0000_0000);
        send_item(CMD_SAMPLE, 32'hFFFF_FFFF, 16'hA5A5, 32'h0000_0000);
        send_item(CMD_UPDATE, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000);
        send_item(CMD_UPDATE, 32'h0000_0000, 16'h0000, 32'h0000_0000);
        // remote adds, counter wrap
        send_item(CMD_REMOTE, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
        send_item(CMD_REMOTE, 32'h0000_0000, 16'h0000, 32'h0000_0001);
        send_item(CMD_REMOTE, 32'h5555_5555, 16'hFFFF, 32'hAAAA_AAAA);
        send_item(CMD_SAMPLE, 32'h7FFF_FFFF, 16'hFFFF, 32'h5555_5555);
        send_item(CMD_UPDATE, 32'hFFFF_FFFE, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_CLEAR, 32'hAAAA_AAAA, 16'hAAAA, 32'h5555_5555);
        send_item(CMD_SAMPLE, 32'h0000_0000, 16'h0000, 32'h0000_0000);
        send_item(CMD_SAMPLE, 32'h0000_0001, 16'h0001, 32'h0000_0000);
        send_item(CMD_UPDATE, 32'h0000_0000, 16'h0000, 32'h0000_0000);
        send_item(CMD_REMOTE, 32'h0000_0000, 16'h0000, 32'h0000_0000);
        send_item(CMD_SAMPLE, 32'h8000_0000, 16'h8000, 32'h0000_0000);
        send_item(CMD_UPDATE, 32'h8000_0000, 16'h7FFF, 32'h0000_0000);
        send_item(CMD_SAMPLE, 32'h8000_EA60, 16'hFFFF, 32'h0000_0000);
        send_item(CMD_UPDATE, 32'h8036_EE80, 16'h0000, 32'h0000_0000);
        send_item(CMD_CLEAR, 32'h0000_0000, 16'h0000, 32'h0000_0000);
    endtask

    // Mostly forward-running samples and updates, some remote adds, rare
    // clears and out-of-order timestamps.
    task automatic run_random(int count);
        int          pick;
        logic [31:0] step;
        logic [15:0] ma;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 19))
                0:       step = 32'd0;
                1:       step = $urandom;
                2, 3, 4: step = $urandom_range(0, 600000);
                default: step = $urandom_range(1, 2000);
            endcase
            clock_ms = clock_ms + step;
            ma = ($urandom_range(0, 9) == 0) ? {16{pick[0]}} : 16'($urandom);
            pace();
            if (pick < 55)
                send_item(CMD_SAMPLE, clock_ms, ma, $urandom);
            else if (pick < 80)
                send_item(CMD_UPDATE, clock_ms, ma, $urandom);
            else if (pick < 89)
                send_item(CMD_REMOTE, $urandom, ma, $urandom);
            else if (pick < 92)
                send_item(CMD_CLEAR, $urandom, ma, $urandom);
            else
                send_item(CMD_SAMPLE, $urandom, ma, $urandom);
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        clock_ms = $urandom;
        run_directed();
        drain();
        write_voltage(9'd511);
        run_random(160);
        drain();
        write_voltage(9'd0);
        run_random(120);
        drain();
        write_voltage(9'd1);
        run_random(120);
        drain();
        write_voltage(9'($urandom));
        run_random(180);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && readings_pending == 0)
            $display("energy_meter_accumulator: match");
        else
            $display("energy_meter_accumulator: mismatch");
        $finish;
    end

endmodule
